[hw/rtl/pale_pkg.sv]
// Shared types and codes of the positional array list engine.
`default_nettype none

package pale_pkg;

    typedef logic [1:0] func_t;
    typedef logic [2:0] status_t;

    localparam func_t FUNC_INSERT   = 2'd0;
    localparam func_t FUNC_DELETE   = 2'd1;
    localparam func_t FUNC_SEARCH   = 2'd2;
    localparam func_t FUNC_TRAVERSE = 2'd3;

    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_BADPOS   = 3'd1;
    localparam status_t ST_FULL     = 3'd2;
    localparam status_t ST_NOTFOUND = 3'd3;
    localparam status_t ST_EMPTY    = 3'd4;

    localparam int POS_W = 5;
    localparam int VAL_W = 32;

endpackage

`default_nettype wire

[hw/rtl/pale_req_if.sv]
// Request channel: one operation per beat.
`default_nettype none

interface pale_req_if;
    import pale_pkg::*;

    logic                    valid;
    logic                    ready;
    func_t                   func;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output func, output position, output value, input ready);
    modport sink   (input valid, input func, input position, input value, output ready);
endinterface

`default_nettype wire

[hw/rtl/pale_rsp_if.sv]
// Response channel: one result per beat.
`default_nettype none

interface pale_rsp_if;
    import pale_pkg::*;

    logic                    valid;
    logic                    ready;
    status_t                 status;
    logic [POS_W-1:0]        found_position;
    logic signed [VAL_W-1:0] entry_value;
    logic                    last;

    modport source (output valid, output status, output found_position,
                    output entry_value, output last, input ready);
    modport sink   (input valid, input status, input found_position,
                    input entry_value, input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/pale_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module pale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/positional_array_list_engine.sv]
// Top level of the positional array list engine: sequencer around one entry RAM.
// Insert moves count+1-position entries, one per cycle, then writes the new value in S_INSV.
// Delete moves count-position entries, one per cycle; search reads one entry per cycle
// until a hit; traverse does a RAM read, once the output is free, then an output load.
// Rejected operations and those needing no move go straight to S_RESP; one item at a time.
// Reset clears the count and all control state; RAM contents stay undefined until written.
`default_nettype none

module positional_array_list_engine #(
    parameter int DEPTH = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pale_req_if.sink    req,
    pale_rsp_if.source  rsp
);
    import pale_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // Common width for comparing a request position against the count.
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_INSV,
        S_DEL,
        S_SRCH,
        S_TRAV,
        S_RESP
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0]  ins_addr_reg, ins_addr_next;
    logic [VAL_W-1:0]   val_reg, val_next;
    logic               rd_pend_reg, rd_pend_next;

    // Result that waits in S_RESP for the output register.
    status_t            res_status_reg, res_status_next;
    logic [POS_W-1:0]   res_pos_reg, res_pos_next;
    logic [VAL_W-1:0]   res_val_reg, res_val_next;

    // Output register, which parts the sequencer from the response channel.
    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [POS_W-1:0]   out_pos_reg, out_pos_next;
    logic [VAL_W-1:0]   out_val_reg, out_val_next;
    logic               out_last_reg, out_last_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [VAL_W-1:0]   ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [VAL_W-1:0]   ram_rdata;

    logic               accept;
    logic               out_free;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   pos_m1;
    logic [CNT_W-1:0]   cnt_m1;
    logic [ADDR_W-1:0]  last_addr;
    logic [POS_W-1:0]   idx_pos;

    pale_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req.ready          = (state_reg == S_IDLE);
    assign accept             = req.valid && req.ready;
    assign out_free           = !out_valid_reg || rsp.ready;

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.found_position = out_pos_reg;
    assign rsp.entry_value    = out_val_reg;
    assign rsp.last           = out_last_reg;

    assign pos_ext   = CMP_W'(req.position);
    assign cnt_ext   = CMP_W'(cnt_reg);
    assign pos_m1    = pos_ext - CMP_W'(1);
    assign cnt_m1    = cnt_reg - CNT_W'(1);
    assign last_addr = cnt_m1[ADDR_W-1:0];
    // One-based position of the entry at idx_reg, cut to the port width.
    assign idx_pos   = POS_W'({1'b0, idx_reg} + (ADDR_W + 1)'(1));

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        ins_addr_next   = ins_addr_reg;
        val_next        = val_reg;
        rd_pend_next    = rd_pend_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_val_next    = res_val_reg;

        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_val_next    = out_val_reg;
        out_last_next   = out_last_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = val_reg;
        ram_re    = 1'b0;
        ram_raddr = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_pos_next    = '0;
                    res_val_next    = '0;
                    val_next        = req.value;
                    state_next      = S_RESP;
                    case (req.func)
                        FUNC_INSERT:
                        begin
                            if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))
                            begin
                                res_status_next = ST_BADPOS;
                            end
                            else if (cnt_ext == CMP_W'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (pos_ext == cnt_ext + CMP_W'(1))
                            begin
                                // Append at the tail: nothing to move.
                                ram_we    = 1'b1;
                                ram_waddr = ADDR_W'(pos_m1);
                                ram_wdata = req.value;
                                cnt_next  = cnt_reg + CNT_W'(1);
                            end
                            else
                            begin
                                ram_re        = 1'b1;
                                ram_raddr     = last_addr;
                                idx_next      = last_addr;
                                ins_addr_next = ADDR_W'(pos_m1);
                                state_next    = S_INS;
                            end
                        end
                        FUNC_DELETE:
                        begin
                            if (pos_ext == '0 || pos_ext > cnt_ext)
                            begin
                                res_status_next = ST_BADPOS;
                            end
                            else if (pos_ext == cnt_ext)
                            begin
                                // Dropping the tail entry moves nothing.
                                cnt_next = cnt_m1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = ADDR_W'(pos_ext);
                                idx_next   = ADDR_W'(pos_ext);
                                state_next = S_DEL;
                            end
                        end
                        FUNC_SEARCH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = ST_NOTFOUND;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                idx_next   = '0;
                                state_next = S_SRCH;
                            end
                        end
                        default:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                idx_next     = '0;
                                rd_pend_next = 1'b0;
                                state_next   = S_TRAV;
                            end
                        end
                    endcase
                end
            end

            S_INS:
            begin
                // Entry at idx_reg is on the read port; move it up by one.
                ram_we    = 1'b1;
                ram_waddr = idx_reg + ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (idx_reg == ins_addr_reg)
                begin
                    state_next = S_INSV;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg - ADDR_W'(1);
                    idx_next  = idx_reg - ADDR_W'(1);
                end
            end

            S_INSV:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ins_addr_reg;
                ram_wdata  = val_reg;
                cnt_next   = cnt_reg + CNT_W'(1);
                state_next = S_RESP;
            end

            S_DEL:
            begin
                // Entry at idx_reg is on the read port; move it down by one.
                ram_we    = 1'b1;
                ram_waddr = idx_reg - ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (idx_reg == last_addr)
                begin
                    cnt_next   = cnt_m1;
                    state_next = S_RESP;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + ADDR_W'(1);
                    idx_next  = idx_reg + ADDR_W'(1);
                end
            end

            S_SRCH:
            begin
                if (ram_rdata == val_reg)
                begin
                    res_status_next = ST_OK;
                    res_pos_next    = idx_pos;
                    res_val_next    = ram_rdata;
                    state_next      = S_RESP;
                end
                else if (idx_reg == last_addr)
                begin
                    res_status_next = ST_NOTFOUND;
                    state_next      = S_RESP;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_reg + ADDR_W'(1);
                    idx_next  = idx_reg + ADDR_W'(1);
                end
            end

            S_TRAV:
            begin
                if (rd_pend_reg)
                begin
                    // The read was issued only with the output free, so it is free now.
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_pos_next    = idx_pos;
                    out_val_next    = ram_rdata;
                    out_last_next   = (idx_reg == last_addr);
                    rd_pend_next    = 1'b0;
                    if (idx_reg == last_addr)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + ADDR_W'(1);
                    end
                end
                else if (out_free)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = idx_reg;
                    rd_pend_next = 1'b1;
                end
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = res_pos_reg;
                    out_val_next    = res_val_reg;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            idx_reg        <= '0;
            ins_addr_reg   <= '0;
            val_reg        <= '0;
            rd_pend_reg    <= 1'b0;
            res_status_reg <= ST_OK;
            res_pos_reg    <= '0;
            res_val_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_pos_reg    <= '0;
            out_val_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            ins_addr_reg   <= ins_addr_next;
            val_reg        <= val_next;
            rd_pend_reg    <= rd_pend_next;
            res_status_reg <= res_status_next;
            res_pos_reg    <= res_pos_next;
            res_val_reg    <= res_val_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_pos_reg    <= out_pos_next;
            out_val_reg    <= out_val_next;
            out_last_reg   <= out_last_next;
        end
    end

    // The count never runs past the capacity of the RAM.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds DEPTH");

    // The count moves by at most one entry per operation.
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |->
            (cnt_reg == $past(cnt_reg) + CNT_W'(1) || cnt_reg == $past(cnt_reg) - CNT_W'(1)))
        else $error("entry count jumped");

    // A traverse read returns only into an empty output register.
    a_trav_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TRAV && rd_pend_reg) |-> !out_valid_reg)
        else $error("traverse data would overwrite a pending beat");

endmodule

`default_nettype wire
